[design/hclp_pkg.sv]
package hclp_pkg;

   // Fixed payload widths
   localparam int BYTE_BITS           = 8;
   localparam int CONTENT_LENGTH_BITS = 31;

   // Character codes
   localparam logic [BYTE_BITS-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   // Header name that carries the body length
   localparam int NAME_LEN = 14;
   localparam int NAME_COUNT_BITS = 4;
   localparam logic [8*NAME_LEN-1:0] MATCH_NAME = "Content-Length";

   typedef enum logic [1:0] {
      VALUE_SKIP   = 2'd0,
      VALUE_DIGITS = 2'd1,
      VALUE_DONE   = 2'd2
   } value_mode_type;

   typedef struct packed {
      value_mode_type mode;
      logic           negative;
   } value_state_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0]           echo_byte;
      logic                           in_header;
      logic                           in_value;
      logic                           line_end;
      logic                           header_end;
      logic                           body_byte;
      logic                           body_last;
      logic                           beyond_body;
      logic                           length_known;
      logic [CONTENT_LENGTH_BITS-1:0] content_length;
   } rsp_payload_type;

   // Character of the match name at a position, zero past its end
   function automatic logic [BYTE_BITS-1:0] name_char(input logic [NAME_COUNT_BITS-1:0] idx);
      logic [BYTE_BITS-1:0] ch;
      ch = '0;
      for (int i = 0; i < NAME_LEN; i++) begin
         if (idx == NAME_COUNT_BITS'(i)) begin
            ch = MATCH_NAME[8*(NAME_LEN-1-i) +: 8];
         end
      end
      return ch;
   endfunction

endpackage

[design/hclp_stream_if.sv]
interface hclp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/hclp_value_step.sv]
// One byte of the atoi-style value scan: skip whitespace, take a sign,
// accumulate decimal digits with saturation at all ones.
module hclp_value_step #(
   parameter int WIDTH = 31
) (
   input  logic [hclp_pkg::BYTE_BITS-1:0] data_byte,
   input  hclp_pkg::value_state_type      state_cur,
   input  logic [WIDTH-1:0]               acc_cur,
   output hclp_pkg::value_state_type      state_nxt,
   output logic [WIDTH-1:0]               acc_nxt
);

   logic             is_digit;
   logic             is_space;
   logic [WIDTH+3:0] acc_times_ten;
   logic [WIDTH-1:0] acc_step;

   assign is_digit = (data_byte >= hclp_pkg::CHAR_ZERO) && (data_byte <= hclp_pkg::CHAR_NINE);
   assign is_space = (data_byte == hclp_pkg::CHAR_SPACE) ||
                     ((data_byte >= hclp_pkg::CHAR_TAB) && (data_byte <= hclp_pkg::CHAR_CR));

   // acc * 10 + digit as shift-and-add; any bit above WIDTH means saturate
   assign acc_times_ten = {3'b000, acc_cur, 1'b0} + {1'b0, acc_cur, 3'b000} +
                          (WIDTH+4)'(data_byte - hclp_pkg::CHAR_ZERO);
   assign acc_step = (|acc_times_ten[WIDTH+3:WIDTH]) ? {WIDTH{1'b1}} :
                                                        acc_times_ten[WIDTH-1:0];

   always_comb begin
      state_nxt = state_cur;
      acc_nxt   = acc_cur;
      case (state_cur.mode)
         hclp_pkg::VALUE_SKIP: begin
            if (is_space) begin
               state_nxt = state_cur;
            end else if ((data_byte == hclp_pkg::CHAR_PLUS) ||
                         (data_byte == hclp_pkg::CHAR_MINUS)) begin
               state_nxt.negative = (data_byte == hclp_pkg::CHAR_MINUS);
               state_nxt.mode     = hclp_pkg::VALUE_DIGITS;
            end else if (is_digit) begin
               state_nxt.mode = hclp_pkg::VALUE_DIGITS;
               acc_nxt        = acc_step;
            end else begin
               state_nxt.mode = hclp_pkg::VALUE_DONE;
            end
         end
         hclp_pkg::VALUE_DIGITS: begin
            if (is_digit) begin
               acc_nxt = acc_step;
            end else begin
               state_nxt.mode = hclp_pkg::VALUE_DONE;
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

[design/http_header_content_length_parser_top.sv]
// Path: a transferred byte passes one input register, then one result register,
//   before it shows on the result channel.
// Throughput: one byte per cycle, every cycle, unless the result side stalls.
// Backpressure: the input register holds while the result register is full and stalled.
// Reset (synchronous, active high): header phase, line start, no length known.
module http_header_content_length_parser_top #(
   parameter int LENGTH_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   hclp_stream_if.sink         req_chan,
   hclp_stream_if.source       rsp_chan
);

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_COUNTED = 2'd1,
      PHASE_OPEN    = 2'd2
   } phase_type;

   // Input stage
   logic                            in_valid_ff, in_valid_in;
   logic [hclp_pkg::BYTE_BITS-1:0]  in_byte_ff,  in_byte_in;

   // Result stage
   logic                            rsp_valid_ff, rsp_valid_in;
   hclp_pkg::rsp_payload_type       rsp_data_ff,  rsp_data_in;

   // Parser state
   phase_type                             phase_ff,           phase_in;
   logic                                  prev_was_cr_ff,     prev_was_cr_in;
   logic                                  at_line_start_ff,   at_line_start_in;
   logic                                  line_name_empty_ff, line_name_empty_in;
   logic                                  colon_seen_ff,      colon_seen_in;
   logic [hclp_pkg::NAME_COUNT_BITS-1:0]  name_count_ff,      name_count_in;
   logic                                  name_mismatch_ff,   name_mismatch_in;
   hclp_pkg::value_state_type             value_state_ff,     value_state_in;
   logic [LENGTH_BITS-1:0]                value_acc_ff,       value_acc_in;
   logic                                  length_found_ff,    length_found_in;
   logic [LENGTH_BITS-1:0]                length_ff,          length_in;
   logic [LENGTH_BITS-1:0]                remaining_ff,       remaining_in;

   logic                            stage_go;
   logic [hclp_pkg::BYTE_BITS-1:0]  cur_byte;
   hclp_pkg::value_state_type       value_state_step;
   logic [LENGTH_BITS-1:0]          value_acc_step;

   // Move the input register into the result register when it holds a byte
   // and the result slot is empty or being drained this cycle.
   assign stage_go       = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || stage_go;
   assign cur_byte       = in_byte_ff;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   hclp_value_step #(
      .WIDTH (LENGTH_BITS)
   ) u_value_step (
      .data_byte (cur_byte),
      .state_cur (value_state_ff),
      .acc_cur   (value_acc_ff),
      .state_nxt (value_state_step),
      .acc_nxt   (value_acc_step)
   );

   // Handshake bookkeeping for both registers
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.data.data_byte;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (stage_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Per-byte parse: tag the byte and advance the line and body state
   always_comb begin
      logic start;
      logic new_line;

      phase_in           = phase_ff;
      prev_was_cr_in     = prev_was_cr_ff;
      at_line_start_in   = at_line_start_ff;
      line_name_empty_in = line_name_empty_ff;
      colon_seen_in      = colon_seen_ff;
      name_count_in      = name_count_ff;
      name_mismatch_in   = name_mismatch_ff;
      value_state_in     = value_state_ff;
      value_acc_in       = value_acc_ff;
      length_found_in    = length_found_ff;
      length_in          = length_ff;
      remaining_in       = remaining_ff;

      rsp_data_in           = '0;
      rsp_data_in.echo_byte = cur_byte;

      start    = at_line_start_ff;
      new_line = 1'b0;

      case (phase_ff)
         PHASE_HEADER: begin
            rsp_data_in.in_header = 1'b1;
            if ((cur_byte == hclp_pkg::CHAR_COLON) && !colon_seen_ff) begin
               // First colon splits name from value; the name must be complete
               rsp_data_in.in_value = 1'b1;
               line_name_empty_in   = start;
               if (name_count_ff != hclp_pkg::NAME_COUNT_BITS'(hclp_pkg::NAME_LEN)) begin
                  name_mismatch_in = 1'b1;
               end
               colon_seen_in    = 1'b1;
               at_line_start_in = 1'b0;
               prev_was_cr_in   = 1'b0;
            end else if ((cur_byte == hclp_pkg::CHAR_LF) && prev_was_cr_ff) begin
               // CR LF closes the line; an empty name closes the header
               rsp_data_in.in_value = colon_seen_ff;
               rsp_data_in.line_end = 1'b1;
               if (line_name_empty_ff) begin
                  rsp_data_in.header_end = 1'b1;
                  if (length_found_ff) begin
                     phase_in     = PHASE_COUNTED;
                     remaining_in = length_ff;
                  end else begin
                     phase_in = PHASE_OPEN;
                  end
               end else if (colon_seen_ff && !name_mismatch_ff && !length_found_ff) begin
                  // Take only the first matching line; negative reads as zero
                  length_found_in = 1'b1;
                  length_in       = value_state_ff.negative ? '0 : value_acc_ff;
               end
               new_line       = 1'b1;
               prev_was_cr_in = 1'b0;
            end else begin
               rsp_data_in.in_value = colon_seen_ff;
               if (colon_seen_ff) begin
                  value_state_in = value_state_step;
                  value_acc_in   = value_acc_step;
               end else begin
                  if ((name_count_ff < hclp_pkg::NAME_COUNT_BITS'(hclp_pkg::NAME_LEN)) &&
                      (cur_byte == hclp_pkg::name_char(name_count_ff))) begin
                     name_count_in = name_count_ff + 1'b1;
                  end else begin
                     name_mismatch_in = 1'b1;
                  end
                  line_name_empty_in = start && (cur_byte == hclp_pkg::CHAR_CR);
               end
               at_line_start_in = 1'b0;
               prev_was_cr_in   = (cur_byte == hclp_pkg::CHAR_CR);
            end
         end
         PHASE_COUNTED: begin
            // Count declared body bytes down; flag the overrun
            if (remaining_ff != '0) begin
               rsp_data_in.body_byte = 1'b1;
               rsp_data_in.body_last = (remaining_ff == LENGTH_BITS'(1));
               remaining_in          = remaining_ff - 1'b1;
            end else begin
               rsp_data_in.beyond_body = 1'b1;
            end
         end
         default: begin
            rsp_data_in.body_byte = 1'b1;
         end
      endcase

      if (new_line) begin
         at_line_start_in   = 1'b1;
         line_name_empty_in = 1'b0;
         colon_seen_in      = 1'b0;
         name_count_in      = '0;
         name_mismatch_in   = 1'b0;
         value_state_in     = '{mode: hclp_pkg::VALUE_SKIP, negative: 1'b0};
         value_acc_in       = '0;
      end

      // Length fields reflect the state after this byte
      rsp_data_in.length_known   = length_found_in;
      rsp_data_in.content_length = hclp_pkg::CONTENT_LENGTH_BITS'(length_in);
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (stage_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         phase_ff           <= PHASE_HEADER;
         prev_was_cr_ff     <= 1'b0;
         at_line_start_ff   <= 1'b1;
         line_name_empty_ff <= 1'b0;
         colon_seen_ff      <= 1'b0;
         name_count_ff      <= '0;
         name_mismatch_ff   <= 1'b0;
         value_state_ff     <= '{mode: hclp_pkg::VALUE_SKIP, negative: 1'b0};
         value_acc_ff       <= '0;
         length_found_ff    <= 1'b0;
         length_ff          <= '0;
         remaining_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Advance parse state only on a byte that moves into the result slot
         if (stage_go) begin
            phase_ff           <= phase_in;
            prev_was_cr_ff     <= prev_was_cr_in;
            at_line_start_ff   <= at_line_start_in;
            line_name_empty_ff <= line_name_empty_in;
            colon_seen_ff      <= colon_seen_in;
            name_count_ff      <= name_count_in;
            name_mismatch_ff   <= name_mismatch_in;
            value_state_ff     <= value_state_in;
            value_acc_ff       <= value_acc_in;
            length_found_ff    <= length_found_in;
            length_ff          <= length_in;
            remaining_ff       <= remaining_in;
         end
      end
   end

   // Once a length is taken it stays taken until reset
   a_length_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(length_found_ff))
      else $error("length_found dropped without reset");

   // A last body byte is always a body byte
   a_last_is_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.body_last |-> rsp_data_ff.body_byte)
      else $error("body_last without body_byte");

   // Header end is a line end inside the header
   a_header_end_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.header_end |->
         rsp_data_ff.line_end && rsp_data_ff.in_header)
      else $error("header_end without line_end/in_header");

   // Body and header tags never overlap
   a_body_not_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.body_byte || rsp_data_ff.beyond_body) |->
         !rsp_data_ff.in_header)
      else $error("body byte tagged as header");

   // No length reported before one is known
   a_length_zero_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.length_known |-> rsp_data_ff.content_length == '0)
      else $error("content_length nonzero while unknown");

endmodule

[bench/hclp_byte_tag_checker.sv]
`timescale 1ns / 1ps

module hclp_byte_tag_checker
   import hclp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   output int              mismatches,
   output int              tags_awaited
);

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_COUNTED = 2'd1,
      PHASE_OPEN    = 2'd2
   } phase_type;

   localparam logic [63:0] LENGTH_MAX = (64'd1 << CONTENT_LENGTH_BITS) - 64'd1;

   // Parser state as the block should hold it
   phase_type                      phase;
   logic                           prev_cr;
   logic                           line_start;
   logic                           name_empty;
   logic                           colon_seen;
   logic [NAME_COUNT_BITS-1:0]     match_count;
   logic                           name_miss;
   value_mode_type                 vmode;
   logic                           vneg;
   logic [CONTENT_LENGTH_BITS-1:0] acc;
   logic                           len_found;
   logic [CONTENT_LENGTH_BITS-1:0] len_reg;
   logic [CONTENT_LENGTH_BITS-1:0] body_left;

   rsp_payload_type expected_tags[$];

   initial mismatches = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report(field, got, want);
   endtask

   function automatic void restart_line();
      line_start  = 1'b1;
      name_empty  = 1'b0;
      colon_seen  = 1'b0;
      match_count = '0;
      name_miss   = 1'b0;
      vmode       = VALUE_SKIP;
      vneg        = 1'b0;
      acc         = '0;
   endfunction

   // Decimal accumulate, pinned at the largest length
   function automatic logic [CONTENT_LENGTH_BITS-1:0] append_digit(
      input logic [CONTENT_LENGTH_BITS-1:0] sofar, input logic [BYTE_BITS-1:0] ch);
      logic [63:0] d;
      logic [63:0] grown;
      d = {56'd0, ch - CHAR_ZERO};
      if ({33'd0, sofar} > (LENGTH_MAX - d) / 64'd10) grown = LENGTH_MAX;
      else grown = {33'd0, sofar} * 64'd10 + d;
      return grown[CONTENT_LENGTH_BITS-1:0];
   endfunction

   function automatic rsp_payload_type predict_tags(input logic [BYTE_BITS-1:0] b);
      rsp_payload_type r;
      logic            start;
      logic            digit;
      logic            blank;
      r = '0;
      r.echo_byte = b;
      digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
      case (phase)
         PHASE_HEADER: begin
            start = line_start;
            r.in_header = 1'b1;
            if (b == CHAR_COLON && !colon_seen) begin
               r.in_value = 1'b1;
               name_empty = start;
               if (match_count != NAME_LEN) name_miss = 1'b1;
               colon_seen = 1'b1;
               line_start = 1'b0;
               prev_cr    = 1'b0;
            end else if (b == CHAR_LF && prev_cr) begin
               r.in_value = colon_seen;
               r.line_end = 1'b1;
               if (name_empty) begin
                  r.header_end = 1'b1;
                  if (len_found) begin
                     phase     = PHASE_COUNTED;
                     body_left = len_reg;
                  end else begin
                     phase = PHASE_OPEN;
                  end
               end else if (colon_seen && !name_miss && !len_found) begin
                  len_found = 1'b1;
                  len_reg   = vneg ? '0 : acc;
               end
               restart_line();
               prev_cr = 1'b0;
            end else begin
               r.in_value = colon_seen;
               if (colon_seen) begin
                  case (vmode)
                     VALUE_SKIP: begin
                        if (blank) begin
                           // skip leading whitespace
                        end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                           vneg  = (b == CHAR_MINUS);
                           vmode = VALUE_DIGITS;
                        end else if (!digit) begin
                           vmode = VALUE_DONE;
                        end else begin
                           vmode = VALUE_DIGITS;
                           acc   = append_digit(acc, b);
                        end
                     end
                     VALUE_DIGITS: begin
                        if (!digit) vmode = VALUE_DONE;
                        else acc = append_digit(acc, b);
                     end
                     default: ;
                  endcase
               end else begin
                  if (match_count < NAME_LEN &&
                      b == MATCH_NAME[8*(NAME_LEN-1-int'(match_count)) +: 8])
                     match_count++;
                  else
                     name_miss = 1'b1;
                  name_empty = start && (b == CHAR_CR);
               end
               line_start = 1'b0;
               prev_cr    = (b == CHAR_CR);
            end
         end
         PHASE_COUNTED: begin
            if (body_left != '0) begin
               r.body_byte = 1'b1;
               r.body_last = (body_left == 1);
               body_left   = body_left - 1'b1;
            end else begin
               r.beyond_body = 1'b1;
            end
         end
         default: r.body_byte = 1'b1;
      endcase
      r.length_known   = len_found;
      r.content_length = len_reg;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         phase     = PHASE_HEADER;
         prev_cr   = 1'b0;
         restart_line();
         len_found = 1'b0;
         len_reg   = '0;
         body_left = '0;
         expected_tags.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tags.size() == 0) begin
               report("unexpected result, echo_byte", rsp_data.echo_byte, '0);
            end else begin
               want = expected_tags.pop_front();
               check_field("echo_byte", rsp_data.echo_byte, want.echo_byte);
               check_field("in_header", rsp_data.in_header, want.in_header);
               check_field("in_value", rsp_data.in_value, want.in_value);
               check_field("line_end", rsp_data.line_end, want.line_end);
               check_field("header_end", rsp_data.header_end, want.header_end);
               check_field("body_byte", rsp_data.body_byte, want.body_byte);
               check_field("body_last", rsp_data.body_last, want.body_last);
               check_field("beyond_body", rsp_data.beyond_body, want.beyond_body);
               check_field("length_known", rsp_data.length_known, want.length_known);
               check_field("content_length", rsp_data.content_length,
                           want.content_length);
            end
         end
         if (req_valid && req_ready)
            expected_tags.push_back(predict_tags(req_data.data_byte));
      end
      tags_awaited <= expected_tags.size();
   end

endmodule

[bench/http_header_content_length_parser_top_tb.sv]
`timescale 1ns / 1ps

module http_header_content_length_parser_top_tb;
   import hclp_pkg::*;

   localparam int ITEM_TARGET   = 1950;
   localparam int HEADER_TARGET = 1350;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_AFTER    = 400;   // transfers sent before the long receiver hold
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 8;     // margin past the two-register path

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   bytes_sent = 0;
   logic hold_results = 1'b0;
   int   mismatches;
   int   tags_awaited;

   logic [BYTE_BITS-1:0] response_bytes[$];

   // Whitespace the length value may start with, CR and LF among them
   logic [BYTE_BITS-1:0] blank_chars[6] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, 8'h0B, 8'h0C,
                                            CHAR_CR};
   // Names that come close to the length header but must not match it
   string near_names[8] = '{"content-length", "Content-Lengt", "Content-LengthX",
                            "Content-Length ", " Content-Length", "Content-length",
                            "Content_Length", "C"};
   string plain_names[5] = '{"Server", "Date", "Content-Type", "X-Trace", "Length"};
   string signs[4] = '{"", "", "+", "-"};

   hclp_stream_if #(.payload_type(req_payload_type)) req_if ();
   hclp_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   http_header_content_length_parser_top #(
      .LENGTH_BITS (CONTENT_LENGTH_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hclp_byte_tag_checker tag_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_if.valid),
      .req_ready    (req_if.ready),
      .req_data     (req_if.data),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_data     (rsp_if.data),
      .mismatches   (mismatches),
      .tags_awaited (tags_awaited)
   );

   // Mostly no gap, often a short one, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic string digit_text(input int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
      return s;
   endfunction

   task automatic put_byte(input logic [BYTE_BITS-1:0] b);
      response_bytes.push_back(b);
   endtask

   // Append a free byte, but never let it close a line by accident
   task automatic put_safe(input logic [BYTE_BITS-1:0] b);
      if (response_bytes.size() > 0 && response_bytes[$] == CHAR_CR && b == CHAR_LF)
         b = "x";
      put_byte(b);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_line_end();
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endtask

   // Value text: leading blanks, sign, digits, then maybe junk after a non-digit
   task automatic put_value(input string sign, input string digits);
      int n;
      n = $urandom_range(0, 3);
      repeat (n) put_safe(blank_chars[$urandom_range(0, 5)]);
      put_text(sign);
      put_text(digits);
      if ($urandom_range(0, 2) == 0) begin
         put_safe(($urandom_range(0, 1) == 0) ? CHAR_COLON : CHAR_SPACE);
         n = $urandom_range(0, 8);
         repeat (n) put_safe(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic put_random_value();
      put_value(signs[$urandom_range(0, 3)], digit_text($urandom_range(0, 12)));
   endtask

   task automatic build_response();
      int    plan;
      int    planned_at;
      int    kind;
      int    n;
      bit    length_given;
      string planned_sign;
      string planned_digits;
      logic [BYTE_BITS-1:0] b;

      // Directed opening line: LF with no CR before it, lone CR, zero byte,
      // all-ones byte, a second colon inside the value
      put_byte(CHAR_LF);
      put_byte(CHAR_CR);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte("A");
      put_byte(CHAR_COLON);
      put_byte(CHAR_COLON);
      put_line_end();
      // the right name without a colon never counts
      put_text("Content-Length");
      put_line_end();

      // Pick how the first real length line reads, which sets the body shape
      plan = $urandom_range(0, 9);
      planned_sign = "";
      case (plan)
         0, 1, 2, 3, 4: begin
            planned_sign   = ($urandom_range(0, 3) == 0) ? "+" : "";
            planned_digits = $sformatf("%s%0d", ($urandom_range(0, 4) == 0) ? "00" : "",
                                       $urandom_range(1, 450));
         end
         5: begin
            planned_sign   = signs[$urandom_range(0, 3)];
            planned_digits = ($urandom_range(0, 1) == 0) ? "0" : "";
         end
         6: begin
            planned_sign   = "-";
            planned_digits = digit_text($urandom_range(1, 12));
         end
         7: begin
            planned_sign = ($urandom_range(0, 1) == 0) ? "+" : "";
            if ($urandom_range(0, 1) == 0) planned_digits = "2147483647";
            else planned_digits = $sformatf("%0d%s", $urandom_range(1, 9),
                                            digit_text($urandom_range(10, 20)));
         end
         8: planned_digits = $sformatf("%0d", $urandom_range(100000, 2147483646));
         default: planned_digits = "";
      endcase
      planned_at = $urandom_range(25, 1100);
      length_given = 1'b0;

      // Header lines, mostly well formed
      while (response_bytes.size() < HEADER_TARGET) begin
         if (!length_given && plan != 9 && response_bytes.size() >= planned_at) begin
            put_text("Content-Length");
            put_byte(CHAR_COLON);
            put_value(planned_sign, planned_digits);
            length_given = 1'b1;
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 15 && length_given) begin
               // later length lines are ignored
               put_text("Content-Length");
               put_byte(CHAR_COLON);
               put_random_value();
            end else if (kind < 35) begin
               put_text(near_names[$urandom_range(0, 7)]);
               put_byte(CHAR_COLON);
               put_random_value();
            end else if (kind < 45) begin
               put_text("Content-Length");
               put_text($sformatf(" %0d", $urandom_range(0, 999)));
            end else if (kind < 75) begin
               put_text(plain_names[$urandom_range(0, 4)]);
               put_byte(CHAR_COLON);
               put_random_value();
               if ($urandom_range(0, 1) == 0) begin
                  put_byte(CHAR_COLON);
                  put_text(digit_text($urandom_range(1, 4)));
               end
            end else begin
               // noise line; keep its first byte from closing the header
               n = $urandom_range(1, 30);
               do b = 8'($urandom_range(0, 255));
               while (b == CHAR_CR || b == CHAR_LF || b == CHAR_COLON);
               put_byte(b);
               repeat (n - 1) put_safe(8'($urandom_range(0, 255)));
            end
         end
         put_line_end();
      end

      // Close the header with a bare line or a line that starts with a colon
      if ($urandom_range(0, 1) == 0) begin
         put_byte(CHAR_COLON);
         n = $urandom_range(0, 10);
         repeat (n) put_safe(8'($urandom_range(0, 255)));
      end
      put_line_end();

      // Body of random bytes, long enough to run past a small declared length
      n = ITEM_TARGET - response_bytes.size();
      if (n < 300) n = 300;
      repeat (n) put_byte(8'($urandom_range(0, 255)));
   endtask

   // Sender: offer every byte of the response, with random gaps and bursts
   initial begin : sender
      int gap;
      int burst_left;
      burst_left = 0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      build_response();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (response_bytes[i]) begin
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else begin
            gap = idle_cycles();
            if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 80);
         end
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.data.data_byte <= response_bytes[i];
         // hold the byte until the transfer happens
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         bytes_sent++;
      end
      req_if.valid <= 1'b0;

      // Drain: let the checker book the last transfer first
      @(posedge clock);
      while (tags_awaited != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Receiver: random stalls, with stretches of steady acceptance
   initial begin : receiver
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            stall_left = idle_cycles();
            run_left   = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 6);
         end
         rsp_if.ready <= !hold_results && (stall_left == 0);
      end
   end

   // Long hold on the result side while bytes keep coming, to back up the input
   initial begin : long_hold
      wait (bytes_sent >= HOLD_AFTER);
      @(posedge clock);
      hold_results <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results <= 1'b0;
   end

   // Watchdog: a hung handshake or a missing result ends here
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
